>>> rtl/rki_pkg.sv
// Shared types and constants for the ramp key interpolator.
// No dependencies; the front end, back end and top level import it.
package rki_pkg;

    // Table depth default and fixed field widths
    localparam int MAX_KEYS_DEF = 16;
    localparam int POS_W        = 17;
    localparam int VAL_W        = 32;
    localparam int SLOT_W       = 4;

    // Serial divider sizing: dividend and divisor widths
    localparam int DIV_NW = 51;
    localparam int DIV_DW = 18;

    // Segment modes
    localparam logic [1:0] MODE_HOLD   = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_SMOOTH = 2'd2;
    localparam logic [1:0] MODE_SPLINE = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_kind;

    // One classified item travelling from front to back
    typedef struct packed {
        t_kind                          kind;
        logic [SLOT_W-1:0]              slot;
        logic [POS_W-1:0]               pos;
        logic [2:0][VAL_W-1:0]          val;
        logic [1:0]                     mode;
        logic [POS_W-1:0]               qt;
    } t_cmd;

    // One key as stored in the table memory
    typedef struct packed {
        logic [POS_W-1:0]               pos;
        logic [2:0][VAL_W-1:0]          val;
        logic [1:0]                     mode;
    } t_key;

endpackage

>>> rtl/rki_ram.sv
// Generic single-port RAM with registered read data.
// No package dependencies.
module rki_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    input  logic [WIDTH-1:0]           i_wdata,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rki_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependencies; sized by its parameters.
module rki_div #(
    parameter int NW = 51,
    parameter int DW = 18
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NW-1:0]   i_num,
    input  logic [DW-1:0]   i_den,
    output logic            o_done,
    output logic [NW-1:0]   o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   rem_sh;
    logic          fits;

    // Trial subtract of the shifted remainder
    assign rem_sh = {r_rem, r_num[NW-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= fits ? DW'(rem_sh - {1'b0, r_den}) : rem_sh[DW-1:0];
                r_num  <= {r_num[NW-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

>>> rtl/rki_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on rki_pkg.
module rki_front #(
    parameter int MAX_KEYS = rki_pkg::MAX_KEYS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_func,
    input  logic [rki_pkg::SLOT_W-1:0]  i_key_slot,
    input  logic [rki_pkg::POS_W-1:0]   i_key_position,
    input  logic [rki_pkg::VAL_W-1:0]   i_key_red,
    input  logic [rki_pkg::VAL_W-1:0]   i_key_green,
    input  logic [rki_pkg::VAL_W-1:0]   i_key_blue,
    input  logic [1:0]                  i_key_mode,
    input  logic [rki_pkg::POS_W-1:0]   i_query_t,
    output logic                        o_cmd_valid,
    output rki_pkg::t_cmd               o_cmd,
    input  logic                        i_cmd_pop
);
    import rki_pkg::*;

    localparam int QD = 2;

    t_cmd       r_q [QD];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    t_cmd       cmd_in;
    logic       keep;
    logic       do_push;
    logic       do_pop;

    // Classify: loads outside the table are dropped here
    always_comb begin
        cmd_in.kind = i_func ? CMD_QUERY : CMD_LOAD;
        cmd_in.slot = i_key_slot;
        cmd_in.pos  = i_key_position;
        cmd_in.val  = {i_key_blue, i_key_green, i_key_red};
        cmd_in.mode = i_key_mode;
        cmd_in.qt   = i_query_t;
        keep        = i_func || (32'(i_key_slot) < MAX_KEYS);
    end

    assign full        = (r_cnt == 2'(QD));
    assign do_push     = push && !full;
    assign do_pop      = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push && keep) begin
                r_q[r_wp] <= cmd_in;
                r_wp      <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push && keep) - 2'(do_pop);
        end
    end

endmodule

>>> rtl/rki_back.sv
// Back end: owns the key table, runs key search, divisions and Hermite terms.
// Depends on rki_pkg, rki_ram and rki_div.
module rki_back #(
    parameter int MAX_KEYS = rki_pkg::MAX_KEYS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [4:0]                  i_key_count,
    input  logic                        i_cmd_valid,
    input  rki_pkg::t_cmd               i_cmd,
    output logic                        o_cmd_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [rki_pkg::VAL_W-1:0]   o_out_red,
    output logic [rki_pkg::VAL_W-1:0]   o_out_green,
    output logic [rki_pkg::VAL_W-1:0]   o_out_blue,
    output logic [1:0]                  o_status
);
    import rki_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    localparam int KW = $clog2(MAX_KEYS + 1);
    localparam int KEY_W = $bits(t_key);
    localparam logic signed [52:0] TAN_HI = 53'sd1 <<< 40;
    localparam logic signed [52:0] TAN_LO = -(53'sd1 <<< 40);
    localparam logic signed [47:0] OUT_HI = 48'sd2147483647;
    localparam logic signed [47:0] OUT_LO = -48'sd2147483648;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_SRD, S_SCMP, S_CLS, S_ERD, S_EWAIT, S_FETCH,
        S_UDIV, S_UWAIT, S_MU2, S_MU3, S_BASIS, S_CH, S_LIN, S_TSEL,
        S_TM, S_TD, S_TW, S_TF, S_A0, S_A1, S_A2, S_A3, S_A4, S_CHEND, S_OUT
    } t_state;

    t_state                   r_state;
    t_cmd                     r_cmd;
    t_key                     r_key [4];
    logic [KW-1:0]            r_idx;
    logic [KW-1:0]            r_inext;
    logic [2:0]               r_fs;
    logic [1:0]               r_ch;
    logic                     r_tsel;
    logic [15:0]              r_u;
    logic [15:0]              r_u2;
    logic signed [17:0]       r_ca, r_cb, r_cc, r_cd;
    logic signed [59:0]       r_prod;
    logic signed [63:0]       r_acc;
    logic signed [41:0]       r_t1, r_t2;
    logic signed [51:0]       r_other;
    logic                     r_neg;
    logic                     r_sat, r_zero, r_empty;
    logic [2:0][VAL_W-1:0]    r_res;
    logic                     r_ovalid;
    logic [2:0][VAL_W-1:0]    r_out;
    logic [1:0]               r_ostat;

    // Table memory and divider hookup
    logic                     ram_we;
    logic [AW-1:0]            ram_addr;
    t_key                     ram_wkey;
    logic [KEY_W-1:0]         ram_rdata;
    t_key                     rkey;
    logic                     div_start;
    logic [DIV_NW-1:0]        div_num;
    logic [DIV_DW-1:0]        div_den;
    logic                     div_done;
    logic [DIV_NW-1:0]        div_q;

    // Datapath helpers
    logic [KW-1:0]            n;
    logic [KW-1:0]            ip;
    logic                     has_prev, has_next;
    logic signed [31:0]       v0, v1, v2, v3;
    logic signed [32:0]       dv21, far_dv;
    logic signed [17:0]       dp, dq1, dq2, dq, dq_abs;
    logic [59:0]              prod_abs;
    logic signed [17:0]       ma;
    logic signed [41:0]       mb;
    logic [15:0]              u3;
    logic signed [19:0]       us, u2s, u3s;
    logic signed [52:0]       tsum, tsh;
    logic signed [41:0]       tclamp;
    logic                     tsat;
    logic signed [47:0]       ash;
    logic [1:0]               mode;
    logic                     out_free;

    rki_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wkey),
        .o_rdata (ram_rdata)
    );

    rki_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign rkey = t_key'(ram_rdata);

    // Effective key count and segment neighbors
    assign n        = (32'(i_key_count) > MAX_KEYS) ? KW'(MAX_KEYS) : KW'(i_key_count);
    assign ip       = r_inext - 1'b1;
    assign has_prev = (ip != '0);
    assign has_next = ({1'b0, r_inext} + 1'b1) < {1'b0, n};

    // Channel values and spacings
    assign v0     = $signed(r_key[0].val[r_ch]);
    assign v1     = $signed(r_key[1].val[r_ch]);
    assign v2     = $signed(r_key[2].val[r_ch]);
    assign v3     = $signed(r_key[3].val[r_ch]);
    assign dv21   = 33'(v2) - 33'(v1);
    assign far_dv = r_tsel ? (33'(v3) - 33'(v2)) : (33'(v1) - 33'(v0));
    assign dp     = $signed({1'b0, r_key[2].pos}) - $signed({1'b0, r_key[1].pos});
    assign dq1    = $signed({1'b0, r_key[1].pos}) - $signed({1'b0, r_key[0].pos});
    assign dq2    = $signed({1'b0, r_key[3].pos}) - $signed({1'b0, r_key[2].pos});
    assign dq     = r_tsel ? dq2 : dq1;
    assign dq_abs = dq[17] ? -dq : dq;
    assign prod_abs = r_prod[59] ? 60'(-r_prod) : 60'(r_prod);
    assign mode   = r_key[1].mode;

    // Hermite basis terms
    assign u3  = r_prod[31:16];
    assign us  = $signed({4'b0, r_u});
    assign u2s = $signed({4'b0, r_u2});
    assign u3s = $signed({4'b0, u3});

    // Tangent: floor half of near plus far term, clamped
    always_comb begin
        tsum   = 53'(dv21) + 53'(r_other);
        tsh    = tsum >>> 1;
        tsat   = 1'b0;
        tclamp = 42'(tsh);
        if (tsh > TAN_HI) begin
            tclamp = 42'(TAN_HI);
            tsat   = 1'b1;
        end else if (tsh < TAN_LO) begin
            tclamp = 42'(TAN_LO);
            tsat   = 1'b1;
        end
    end

    assign ash      = r_acc[63:16];
    assign out_free = !r_ovalid || pop;

    // Shared multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        case (r_state)
            S_MU2: begin
                ma = $signed({2'b0, r_u});
                mb = 42'(r_u);
            end
            S_MU3: begin
                ma = $signed({2'b0, r_u});
                mb = 42'(r_prod[31:16]);
            end
            S_CH: begin
                ma = $signed({2'b0, r_u});
                mb = 42'(dv21);
            end
            S_TM: begin
                ma = dp;
                mb = 42'(far_dv);
            end
            S_A0: begin
                ma = r_ca;
                mb = 42'(v1);
            end
            S_A1: begin
                ma = r_cb;
                mb = 42'(v2);
            end
            S_A2: begin
                ma = r_cc;
                mb = r_t1;
            end
            S_A3: begin
                ma = r_cd;
                mb = r_t2;
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // Memory port and divider start
    always_comb begin
        ram_we    = (r_state == S_LOAD);
        ram_wkey.pos  = r_cmd.pos;
        ram_wkey.val  = r_cmd.val;
        ram_wkey.mode = r_cmd.mode;
        ram_addr  = r_idx[AW-1:0];
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            S_LOAD:  ram_addr = AW'(r_cmd.slot);
            S_ERD:   ram_addr = (r_inext == n) ? AW'(n - 1'b1) : '0;
            S_FETCH: begin
                case (r_fs)
                    3'd0:    ram_addr = has_prev ? AW'(ip - 1'b1) : AW'(ip);
                    3'd1:    ram_addr = AW'(ip);
                    3'd2:    ram_addr = AW'(r_inext);
                    default: ram_addr = has_next ? AW'(r_inext + 1'b1) : AW'(r_inext);
                endcase
            end
            S_UDIV: begin
                div_start = 1'b1;
                div_num   = DIV_NW'({POS_W'(r_cmd.qt - r_key[1].pos), 16'b0});
                div_den   = DIV_DW'(dp);
            end
            S_TD: begin
                div_start = (dq != '0);
                div_num   = prod_abs[DIV_NW-1:0];
                div_den   = DIV_DW'(dq_abs);
            end
            default: ram_addr = r_idx[AW-1:0];
        endcase
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_prod <= ma * mb;
            if (pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_sat   <= 1'b0;
                        r_zero  <= 1'b0;
                        r_empty <= 1'b0;
                        r_idx   <= '0;
                        if (i_cmd.kind == CMD_LOAD) begin
                            r_state <= S_LOAD;
                        end else if (n == '0) begin
                            r_empty <= 1'b1;
                            r_res   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SRD;
                        end
                    end
                end
                S_LOAD: r_state <= S_IDLE;
                S_SRD:  r_state <= S_SCMP;
                S_SCMP: begin
                    if (r_cmd.qt < rkey.pos) begin
                        r_inext <= r_idx;
                        r_state <= S_CLS;
                    end else if (r_idx + 1'b1 == n) begin
                        r_inext <= n;
                        r_state <= S_CLS;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_CLS: begin
                    r_fs <= '0;
                    if (r_inext == n || r_inext == '0) begin
                        r_state <= S_ERD;
                    end else begin
                        r_state <= S_FETCH;
                    end
                end
                S_ERD:  r_state <= S_EWAIT;
                S_EWAIT: begin
                    r_res   <= rkey.val;
                    r_state <= S_OUT;
                end
                S_FETCH: begin
                    if (r_fs != 3'd0) begin
                        r_key[2'(r_fs - 1'b1)] <= rkey;
                    end
                    r_fs <= r_fs + 1'b1;
                    if (r_fs == 3'd4) begin
                        r_state <= S_UDIV;
                    end
                end
                S_UDIV: r_state <= S_UWAIT;
                S_UWAIT: begin
                    if (div_done) begin
                        r_u     <= (|div_q[DIV_NW-1:16]) ? 16'hFFFF : div_q[15:0];
                        r_state <= S_MU2;
                    end
                end
                S_MU2: r_state <= S_MU3;
                S_MU3: begin
                    r_u2    <= r_prod[31:16];
                    r_state <= S_BASIS;
                end
                S_BASIS: begin
                    r_ca    <= 18'(20'sd2 * u3s - 20'sd3 * u2s + 20'sd65536);
                    r_cb    <= 18'(20'sd3 * u2s - 20'sd2 * u3s);
                    r_cc    <= 18'(u3s - 20'sd2 * u2s + us);
                    r_cd    <= 18'(u3s - u2s);
                    r_ch    <= 2'd0;
                    r_state <= S_CH;
                end
                S_CH: begin
                    case (mode)
                        MODE_HOLD: begin
                            r_acc   <= 64'(v1) <<< 16;
                            r_state <= S_CHEND;
                        end
                        MODE_LINEAR: r_state <= S_LIN;
                        MODE_SMOOTH: r_state <= S_A0;
                        default: begin
                            r_tsel  <= 1'b0;
                            r_state <= S_TSEL;
                        end
                    endcase
                end
                S_LIN: begin
                    r_acc   <= (64'(v1) <<< 16) + 64'(r_prod);
                    r_state <= S_CHEND;
                end
                S_TSEL: begin
                    if (!r_tsel) begin
                        if (has_prev) begin
                            r_state <= S_TM;
                        end else begin
                            r_t1   <= 42'(dv21);
                            r_tsel <= 1'b1;
                        end
                    end else if (has_next) begin
                        r_state <= S_TM;
                    end else begin
                        r_t2    <= 42'(dv21);
                        r_state <= S_A0;
                    end
                end
                S_TM: r_state <= S_TD;
                S_TD: begin
                    if (dq == '0) begin
                        r_zero  <= 1'b1;
                        r_other <= '0;
                        r_state <= S_TF;
                    end else begin
                        r_neg   <= r_prod[59] ^ dq[17];
                        r_state <= S_TW;
                    end
                end
                S_TW: begin
                    if (div_done) begin
                        r_other <= r_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
                        r_state <= S_TF;
                    end
                end
                S_TF: begin
                    if (tsat) begin
                        r_sat <= 1'b1;
                    end
                    if (!r_tsel) begin
                        r_t1    <= tclamp;
                        r_tsel  <= 1'b1;
                        r_state <= S_TSEL;
                    end else begin
                        r_t2    <= tclamp;
                        r_state <= S_A0;
                    end
                end
                S_A0: r_state <= S_A1;
                S_A1: begin
                    r_acc   <= 64'(r_prod);
                    r_state <= S_A2;
                end
                S_A2: begin
                    r_acc   <= r_acc + 64'(r_prod);
                    r_state <= (mode == MODE_SMOOTH) ? S_CHEND : S_A3;
                end
                S_A3: begin
                    r_acc   <= r_acc + 64'(r_prod);
                    r_state <= S_A4;
                end
                S_A4: begin
                    r_acc   <= r_acc + 64'(r_prod);
                    r_state <= S_CHEND;
                end
                S_CHEND: begin
                    if (ash > OUT_HI) begin
                        r_res[r_ch] <= VAL_W'(OUT_HI);
                        r_sat       <= 1'b1;
                    end else if (ash < OUT_LO) begin
                        r_res[r_ch] <= VAL_W'(OUT_LO);
                        r_sat       <= 1'b1;
                    end else begin
                        r_res[r_ch] <= VAL_W'(ash);
                    end
                    if (r_ch == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_CH;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_out    <= r_res;
                        r_ostat  <= r_empty ? ST_EMPTY :
                                    r_sat   ? ST_SAT   :
                                    r_zero  ? ST_ZERO  : ST_OK;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign empty       = !r_ovalid;
    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];
    assign o_status    = r_ostat;

endmodule

>>> rtl/ramp_key_interpolator.sv
// Ramp key interpolator: keyframe table with hold, linear, smooth and spline segments.
// Load: the back end writes the key into the table. Query: pick up, search keys in order,
// classify, fetch four keys, divide for the fraction, form the basis terms, then for each
// channel run up to two tangent divides plus the multiply-accumulate steps, and output.
// One item is processed at a time; a two-entry queue and the result register let
// both sides stall apart. Synchronous active-low reset clears control and key_count.
module ramp_key_interpolator #(
    parameter int MAX_KEYS = rki_pkg::MAX_KEYS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_func,
    input  logic [rki_pkg::SLOT_W-1:0]  i_key_slot,
    input  logic [rki_pkg::POS_W-1:0]   i_key_position,
    input  logic [rki_pkg::VAL_W-1:0]   i_key_red,
    input  logic [rki_pkg::VAL_W-1:0]   i_key_green,
    input  logic [rki_pkg::VAL_W-1:0]   i_key_blue,
    input  logic [1:0]                  i_key_mode,
    input  logic [rki_pkg::POS_W-1:0]   i_query_t,
    output logic                        empty,
    input  logic                        pop,
    output logic [rki_pkg::VAL_W-1:0]   o_out_red,
    output logic [rki_pkg::VAL_W-1:0]   o_out_green,
    output logic [rki_pkg::VAL_W-1:0]   o_out_blue,
    output logic [1:0]                  o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [4:0]                  i_cfg_key_count
);
    import rki_pkg::*;

    logic [4:0] r_key_count;
    logic       cmd_valid;
    t_cmd       cmd;
    logic       cmd_pop;

    // Configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= 5'd0;
        end else if (i_cfg_valid) begin
            r_key_count <= i_cfg_key_count;
        end
    end

    rki_front #(.MAX_KEYS(MAX_KEYS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_key_slot     (i_key_slot),
        .i_key_position (i_key_position),
        .i_key_red      (i_key_red),
        .i_key_green    (i_key_green),
        .i_key_blue     (i_key_blue),
        .i_key_mode     (i_key_mode),
        .i_query_t      (i_query_t),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    rki_back #(.MAX_KEYS(MAX_KEYS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_count (r_key_count),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_status    (o_status)
    );

endmodule
